### hw/rtl/avsfd_pkg.sv
// Shared types, widths and constants for the audio-video sync frame timer.
package avsfd_pkg;

    // Field widths
    localparam int TIME_W   = 40;
    localparam int PEND_W   = 20;
    localparam int DELAY_W  = 20;
    localparam int THR_W    = 20;
    localparam int NOSYNC_W = 27;
    localparam int MIN_W    = 20;
    localparam int CHAN_W   = 4;
    localparam int RATE_W   = 18;
    localparam int MS_W     = 16;
    localparam int ACT_W    = 2;
    localparam int CFG_W    = 27;
    localparam int IDX_W    = 3;

    // Derived datapath widths
    localparam int SCALE_W = 20;
    localparam int PROD_W  = PEND_W + SCALE_W;
    localparam int BPS_W   = RATE_W + CHAN_W + 1;
    localparam int WIDE_W  = ((TIME_W > PROD_W) ? TIME_W : PROD_W) + 2;
    localparam int DIV_W   = PROD_W;
    localparam int TMR_W   = TIME_W + 1;

    // Constants
    localparam logic [SCALE_W-1:0] ONE_SECOND_US = SCALE_W'(1000000);
    localparam logic [MS_W-1:0]    MS_MAX        = {MS_W{1'b1}};
    localparam logic [MS_W-1:0]    IDLE_MS       = MS_W'(100);
    localparam logic [MS_W-1:0]    EMPTY_MS      = MS_W'(1);
    localparam logic [MS_W-1:0]    MS_ONE        = MS_W'(1);
    localparam logic [BPS_W-1:0]   US_PER_MS     = BPS_W'(1000);
    localparam logic [WIDE_W-1:0]  HALF_MS       = WIDE_W'(500);
    localparam logic [WIDE_W-1:0]  SAT_US        = WIDE_W'(65535 * 1000 + 500);
    localparam logic [DELAY_W-1:0] DELAY_RST     = DELAY_W'(40000);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SYNC_THR   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_NOSYNC_THR = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_MIN_DELAY  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_AUDIO_EN   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_CHANNELS   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_RATE       = IDX_W'(5);

    // Sync action codes
    localparam logic [ACT_W-1:0] ACT_KEEP   = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_ZERO   = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_DOUBLE = ACT_W'(2);

    typedef struct packed {
        logic              video_active;
        logic              queue_empty;
        logic [TIME_W-1:0] frame_time_us;
        logic [TIME_W-1:0] audio_time_us;
        logic [PEND_W-1:0] audio_pending_bytes;
        logic [TIME_W-1:0] now_us;
    } in_item_t;

    typedef struct packed {
        logic [MS_W-1:0]  refresh_ms;
        logic             frame_shown;
        logic [ACT_W-1:0] sync_action;
    } out_item_t;

    typedef struct packed {
        logic [THR_W-1:0]    sync_thr;
        logic [NOSYNC_W-1:0] nosync_thr;
        logic [MIN_W-1:0]    min_delay;
        logic                audio_en;
        logic [CHAN_W-1:0]   channels;
        logic [RATE_W-1:0]   rate;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORR,
        ST_CORR_WAIT,
        ST_SYNC,
        ST_ACT,
        ST_TIMER,
        ST_CLAMP,
        ST_ROUND,
        ST_ROUND_WAIT,
        ST_DONE
    } fsm_t;

endpackage

### hw/rtl/avsfd_cfg.sv
// Configuration register file for the sync frame timer.
module avsfd_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [avsfd_pkg::IDX_W-1:0]          cfg_index,
    input  logic [avsfd_pkg::CFG_W-1:0]          cfg_data,
    output avsfd_pkg::cfg_t                      cfg
);
    import avsfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_THR:   cfg_next.sync_thr   = cfg_data[THR_W-1:0];
                REG_NOSYNC_THR: cfg_next.nosync_thr = cfg_data[NOSYNC_W-1:0];
                REG_MIN_DELAY:  cfg_next.min_delay  = cfg_data[MIN_W-1:0];
                REG_AUDIO_EN:   cfg_next.audio_en   = cfg_data[0];
                REG_CHANNELS:   cfg_next.channels   = cfg_data[CHAN_W-1:0];
                REG_RATE:       cfg_next.rate       = cfg_data[RATE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_thr   <= THR_W'(10000);
            cfg_reg.nosync_thr <= NOSYNC_W'(10000000);
            cfg_reg.min_delay  <= MIN_W'(10000);
            cfg_reg.audio_en   <= 1'b1;
            cfg_reg.channels   <= CHAN_W'(2);
            cfg_reg.rate       <= RATE_W'(44100);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/avsfd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module avsfd_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [avsfd_pkg::DIV_W-1:0]        dividend,
    input  logic [avsfd_pkg::BPS_W-1:0]        divisor,
    output logic [avsfd_pkg::DIV_W-1:0]        quotient,
    output avsfd_pkg::div_stat_t               stat
);
    import avsfd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [BPS_W-1:0] rem_reg, rem_next;
    logic [BPS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [BPS_W:0]   rem_shift;
    logic [BPS_W:0]   trial;

    // quo_reg shifts the dividend out at the top and the quotient in below
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        trial     = rem_shift - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[BPS_W])
            begin
                rem_next = trial[BPS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[BPS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

### hw/rtl/av_sync_frame_delay.sv
// Top level of the audio-video sync frame timer.
//
// One request per refresh event, one response per request. With no video the
// response is 100 ms, with an empty picture queue 1 ms; such an event passes
// the PREP and DONE states only. Otherwise the block takes the picture: it
// derives the frame delay from the timestamp step (falling back to the last
// good delay), corrects the audio clock by the buffered bytes over the byte
// rate, zeroes or doubles the delay when the skew reaches the threshold within
// the no-sync limit, advances the frame timer and answers the time left to it
// in rounded milliseconds, floored at min_delay_us. A single bit-serial
// divider does both the audio correction and the microsecond to millisecond
// rounding. The first division is skipped with audio disabled or a zero byte
// rate. The second is skipped when the delay saturates. One request is in work
// at a time. The response sits in an output register, so a new request is
// taken while the previous response waits for its transfer. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce. Writes to
// indexes past the last register are ignored.
module av_sync_frame_delay (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  avsfd_pkg::in_item_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output avsfd_pkg::out_item_t          rsp,
    input  logic                          cfg_we,
    input  logic [avsfd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [avsfd_pkg::CFG_W-1:0]   cfg_data
);
    import avsfd_pkg::*;

    cfg_t cfg;

    fsm_t state_reg, state_next;

    // Architectural state
    logic [DELAY_W-1:0] last_delay_reg;
    logic [TIME_W-1:0]  last_frame_reg;
    logic [TMR_W-1:0]   timer_reg;
    logic               loaded_reg;

    // Working registers for the request in flight
    in_item_t           in_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [BPS_W-1:0]   bps_reg;
    logic [PROD_W-1:0]  corr_reg;
    logic [WIDE_W-1:0]  diff_reg;
    logic [DELAY_W:0]   adj_reg;
    logic [WIDE_W-1:0]  act_reg;
    out_item_t          res_reg;

    // Output register
    logic               rsp_valid_reg;
    out_item_t          rsp_reg;

    // Divider hookup
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [BPS_W-1:0]   div_divisor;
    logic [DIV_W-1:0]   div_quo;
    div_stat_t          div_stat;

    // Combinational datapath terms
    logic                   picture;
    logic [TIME_W:0]        step;
    logic                   step_ok;
    logic [DELAY_W-1:0]     delay_sel;
    logic [RATE_W+CHAN_W-1:0] rate_chan;
    logic                   use_div;
    logic [THR_W-1:0]       thr;
    logic signed [WIDE_W-1:0] diff_s, thr_s, actual_s, min_s;
    logic [WIDE_W-1:0]      mag;
    logic                   in_window;
    logic [TMR_W-1:0]       timer_base;
    logic                   saturate;
    logic [MS_W-1:0]        quo_ms;
    logic                   rsp_load;

    avsfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    avsfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Datapath terms
    always_comb
    begin
        picture   = in_reg.video_active && !in_reg.queue_empty;
        // timestamp step, valid only when positive and under one second
        step      = {1'b0, in_reg.frame_time_us} - {1'b0, last_frame_reg};
        step_ok   = !step[TIME_W] && (step != '0)
                    && (step < (TIME_W+1)'(ONE_SECOND_US));
        delay_sel = step_ok ? step[DELAY_W-1:0] : last_delay_reg;
        rate_chan = (RATE_W+CHAN_W)'(cfg.rate) * (RATE_W+CHAN_W)'(cfg.channels);
        use_div   = cfg.audio_en && (bps_reg != '0);

        thr       = (delay_reg > cfg.sync_thr) ? delay_reg : cfg.sync_thr;
        diff_s    = $signed(diff_reg);
        thr_s     = $signed(WIDE_W'(thr));
        mag       = diff_reg[WIDE_W-1] ? (~diff_reg + WIDE_W'(1)) : diff_reg;
        in_window = mag < WIDE_W'(cfg.nosync_thr);

        // first picture loads the timer from the current time
        timer_base = loaded_reg ? timer_reg : {1'b0, in_reg.now_us};

        actual_s  = $signed(WIDE_W'(timer_reg) - WIDE_W'(in_reg.now_us));
        min_s     = $signed(WIDE_W'(cfg.min_delay));
        saturate  = act_reg >= SAT_US;
        quo_ms    = div_quo[MS_W-1:0];

        rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (req_valid)
                    state_next = ST_PREP;
            ST_PREP:
                state_next = picture ? ST_CORR : ST_DONE;
            ST_CORR:
                state_next = use_div ? ST_CORR_WAIT : ST_SYNC;
            ST_CORR_WAIT:
                if (div_stat.done)
                    state_next = ST_SYNC;
            ST_SYNC:
                state_next = ST_ACT;
            ST_ACT:
                state_next = ST_TIMER;
            ST_TIMER:
                state_next = ST_CLAMP;
            ST_CLAMP:
                state_next = ST_ROUND;
            ST_ROUND:
                state_next = saturate ? ST_DONE : ST_ROUND_WAIT;
            ST_ROUND_WAIT:
                if (div_stat.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (rsp_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        req_ready    = 1'b0;
        div_start    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = bps_reg;
        case (state_reg)
            ST_IDLE:
                req_ready = 1'b1;
            ST_CORR:
                div_start = use_div;
            ST_ROUND:
            begin
                // the division starts only with act_reg below SAT_US, so the sum fits the dividend
                div_start    = !saturate;
                div_dividend = DIV_W'(act_reg + HALF_MS);
                div_divisor  = US_PER_MS;
            end
            default:
                req_ready = 1'b0;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_delay_reg <= DELAY_RST;
            last_frame_reg <= '0;
            timer_reg      <= '0;
            loaded_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_PREP && picture)
            begin
                last_delay_reg <= delay_sel;
                last_frame_reg <= in_reg.frame_time_us;
            end
            if (state_reg == ST_TIMER)
            begin
                // wraps at the timer width
                timer_reg  <= timer_base + TMR_W'(adj_reg);
                loaded_reg <= 1'b1;
            end
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (req_valid)
                    in_reg <= req;
            ST_PREP:
            begin
                delay_reg           <= delay_sel;
                prod_reg            <= PROD_W'(in_reg.audio_pending_bytes)
                                       * PROD_W'(ONE_SECOND_US);
                bps_reg             <= {rate_chan, 1'b0};
                res_reg.frame_shown <= picture;
                res_reg.sync_action <= ACT_KEEP;
                res_reg.refresh_ms  <= in_reg.video_active ? EMPTY_MS : IDLE_MS;
            end
            ST_CORR:
                if (!use_div)
                    corr_reg <= '0;
            ST_CORR_WAIT:
                if (div_stat.done)
                    corr_reg <= div_quo;
            ST_SYNC:
                // skew of picture against the corrected audio clock
                diff_reg <= WIDE_W'(in_reg.frame_time_us) + WIDE_W'(corr_reg)
                            - WIDE_W'(in_reg.audio_time_us);
            ST_ACT:
            begin
                if (in_window && (diff_s <= -thr_s))
                begin
                    adj_reg             <= '0;
                    res_reg.sync_action <= ACT_ZERO;
                end
                else if (in_window && (diff_s >= thr_s))
                begin
                    adj_reg             <= {delay_reg, 1'b0};
                    res_reg.sync_action <= ACT_DOUBLE;
                end
                else
                begin
                    adj_reg             <= {1'b0, delay_reg};
                    res_reg.sync_action <= ACT_KEEP;
                end
            end
            ST_CLAMP:
                act_reg <= (actual_s < min_s) ? WIDE_W'(min_s) : WIDE_W'(actual_s);
            ST_ROUND:
                if (saturate)
                    res_reg.refresh_ms <= MS_MAX;
            ST_ROUND_WAIT:
                if (div_stat.done)
                    res_reg.refresh_ms <= (quo_ms == '0) ? MS_ONE : quo_ms;
            default:
                res_reg <= res_reg;
        endcase
        if (rsp_load)
            rsp_reg <= res_reg;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The divider is shared; a new division never starts on top of one in flight
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // Without a shown picture no sync action is reported
    a_noshow_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.frame_shown) |-> (rsp.sync_action == ACT_KEEP))
        else $error("sync action on a response without a picture");

    // Refresh delay never reads zero
    a_ms_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.refresh_ms != '0))
        else $error("zero refresh delay");

    // An accepted request always enters the preparation step
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_PREP))
        else $error("accepted request not started");

endmodule

### dv/tb_av_sync_frame_delay.sv
// Self-checking testbench for av_sync_frame_delay: directed and random refresh events.
module tb_av_sync_frame_delay;

    timeunit 1ns;
    timeprecision 1ps;

    import avsfd_pkg::*;

    // Long receiver hold used to back the block up into its input.
    localparam int HOLD_CYCLES = 400;
    // Items per random phase, and the number of register settings walked through.
    localparam int PHASE_ITEMS = 116;
    localparam int NUM_SETTINGS = 8;
    // Register write order for a full setting.
    localparam logic [IDX_W-1:0] REG_ORDER [6] = '{REG_SYNC_THR, REG_NOSYNC_THR,
        REG_MIN_DELAY, REG_AUDIO_EN, REG_CHANNELS, REG_RATE};

    // ------------------------------------------------------------------
    // Refresh scoreboard: keeps its own copy of the registers and the
    // timing state, works out the expected response for every accepted
    // request and compares responses in order.
    // ------------------------------------------------------------------
    class refresh_sb;
        longint sync_thr, nosync_thr, min_dly, aud_en, chans, rate;
        longint last_delay, last_pts;
        logic [TMR_W-1:0] pic_timer;
        bit timer_loaded;
        out_item_t expq[$];
        int errors;

        function new();
            sync_thr = 10000;
            nosync_thr = 10000000;
            min_dly = 10000;
            aud_en = 1;
            chans = 2;
            rate = 44100;
            last_delay = longint'(DELAY_RST);
            last_pts = 0;
            pic_timer = '0;
            timer_loaded = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_SYNC_THR:   sync_thr   = longint'(data[THR_W-1:0]);
                REG_NOSYNC_THR: nosync_thr = longint'(data[NOSYNC_W-1:0]);
                REG_MIN_DELAY:  min_dly    = longint'(data[MIN_W-1:0]);
                REG_AUDIO_EN:   aud_en     = longint'(data[0]);
                REG_CHANNELS:   chans      = longint'(data[CHAN_W-1:0]);
                REG_RATE:       rate       = longint'(data[RATE_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_input(in_item_t it);
            out_item_t want;
            longint dly, skew, thr, mag, left, corr, bps, pts;
            want.refresh_ms = IDLE_MS;
            want.frame_shown = 1'b0;
            want.sync_action = ACT_KEEP;
            if (it.video_active && it.queue_empty)
                want.refresh_ms = EMPTY_MS;
            else if (it.video_active)
            begin
                pts = longint'(it.frame_time_us);
                // timestamp step, bad steps fall back to the last good one
                dly = pts - last_pts;
                if (dly <= 0 || dly >= 1000000)
                    dly = last_delay;
                last_delay = dly;
                last_pts = pts;
                // audio clock less what is still sitting in the buffer
                bps = rate * chans * 2;
                corr = 0;
                if (aud_en != 0 && bps != 0)
                    corr = longint'(it.audio_pending_bytes) * 1000000 / bps;
                skew = pts - (longint'(it.audio_time_us) - corr);
                thr = (dly > sync_thr) ? dly : sync_thr;
                mag = (skew < 0) ? -skew : skew;
                if (mag < nosync_thr)
                begin
                    if (skew <= -thr)
                    begin
                        dly = 0;
                        want.sync_action = ACT_ZERO;
                    end
                    else if (skew >= thr)
                    begin
                        dly = 2 * dly;
                        want.sync_action = ACT_DOUBLE;
                    end
                end
                if (!timer_loaded)
                begin
                    pic_timer = {1'b0, it.now_us};
                    timer_loaded = 1'b1;
                end
                pic_timer = pic_timer + TMR_W'(dly);
                left = longint'(pic_timer) - longint'(it.now_us);
                if (left < min_dly)
                    left = min_dly;
                left = (left + 500) / 1000;
                if (left > 65535)
                    left = 65535;
                if (left == 0)
                    left = 1;
                want.refresh_ms = MS_W'(left);
                want.frame_shown = 1'b1;
            end
            expq.push_back(want);
        endfunction

        function void report(string what, longint wantv, longint gotv);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, wantv, gotv);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expq.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response, expected none, got ms %0d", $time,
                         got.refresh_ms);
                return;
            end
            want = expq.pop_front();
            if (got.refresh_ms !== want.refresh_ms)
                report("refresh_ms", want.refresh_ms, got.refresh_ms);
            if (got.frame_shown !== want.frame_shown)
                report("frame_shown", want.frame_shown, got.frame_shown);
            if (got.sync_action !== want.sync_action)
                report("sync_action", want.sync_action, got.sync_action);
        endfunction

        function int pending();
            return expq.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT hookup
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    in_item_t req;
    logic rsp_valid;
    logic rsp_ready;
    out_item_t rsp;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // Handshake knobs shared between the main sequence and the receiver.
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit hold_req = 1'b0;

    refresh_sb sb = new();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    av_sync_frame_delay u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Idle stretch length: mostly short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(3, 1);
        else if (r < 95)
            return $urandom_range(12, 4);
        return $urandom_range(100, 20);
    endfunction

    function automatic int send_gap();
        if (tx_quiet || $urandom_range(99) < 55)
            return 0;
        return idle_len();
    endfunction

    // One refresh event. Most are plausible pictures that follow the running
    // timestamp and frame timer so the sync and timer paths get exercised;
    // the rest are idle/empty events and pictures with random fields.
    function automatic in_item_t random_event();
        in_item_t it;
        int kind, r;
        longint step, skew, left, pts;
        it.video_active = 1'b1;
        it.queue_empty = 1'b0;
        it.frame_time_us = rand_time();
        it.audio_time_us = rand_time();
        it.audio_pending_bytes = PEND_W'($urandom);
        it.now_us = rand_time();
        kind = $urandom_range(99);
        if (kind < 5)
        begin
            it.video_active = 1'b0;
            it.queue_empty = 1'($urandom_range(1));
        end
        else if (kind < 10)
            it.queue_empty = 1'b1;
        else if (kind >= 20)
        begin
            // frame step: normal, zero, backward, too long, and the edges of the good range
            r = $urandom_range(99);
            if (r < 70)
                step = $urandom_range(60000, 15000);
            else if (r < 76)
                step = 0;
            else if (r < 82)
                step = -longint'($urandom_range(2000000, 1));
            else if (r < 88)
                step = $urandom_range(5000000, 1000000);
            else if (r < 91)
                step = 1;
            else if (r < 94)
                step = 999999;
            else if (r < 97)
                step = 1000000;
            else
                step = $urandom_range(999999, 1);
            pts = sb.last_pts + step;
            it.frame_time_us = TIME_W'(pts);

            // audio/video skew: in sync, around the threshold, far, near no-sync
            r = $urandom_range(99);
            if (r < 40)
                skew = $urandom_range(15000, 0);
            else if (r < 65)
                skew = $urandom_range(150000, 15000);
            else if (r < 80)
                skew = $urandom_range(2000000, 150000);
            else
                skew = $urandom_range(10100000, 9900000);
            if ($urandom_range(1))
                skew = -skew;
            if (r < 92)
                it.audio_time_us = TIME_W'(pts - skew);

            r = $urandom_range(99);
            if (r < 50)
                it.audio_pending_bytes = PEND_W'($urandom_range(2000));
            else if (r < 80)
                it.audio_pending_bytes = PEND_W'($urandom_range(65535));

            // time left to the frame timer: normal, tiny, overdue, far off
            r = $urandom_range(99);
            if (r < 60)
                left = $urandom_range(90000, 0);
            else if (r < 75)
                left = $urandom_range(1500, 0);
            else if (r < 85)
                left = -longint'($urandom_range(1000000, 0));
            else if (r < 95)
                left = $urandom_range(70000000, 1000000);
            if (sb.timer_loaded && r < 95)
                it.now_us = TIME_W'(longint'(sb.pic_timer) + step - left);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one request after an idle gap and hold it until the transfer.
    // Called at a rising edge; returns at the edge of the transfer.
    task automatic send_item(in_item_t it, int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_input(it);
    endtask

    // Picture relative to the current state: timestamp step, audio skew,
    // buffered bytes and the intended time left to the frame timer.
    task automatic send_picture(longint step, longint skew, logic [PEND_W-1:0] pend,
                                longint left);
        in_item_t it;
        longint pts;
        pts = sb.last_pts + step;
        it.video_active = 1'b1;
        it.queue_empty = 1'b0;
        it.frame_time_us = TIME_W'(pts);
        it.audio_time_us = TIME_W'(pts - skew);
        it.audio_pending_bytes = pend;
        it.now_us = TIME_W'(longint'(sb.pic_timer) + step - left);
        send_item(it, 0);
    endtask

    // Stop offering and wait for every outstanding response, then keep
    // waiting so the block is surely back in idle.
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Full register setting, only issued while the block is idle.
    task automatic program_setting(int k);
        logic [CFG_W-1:0] vals [6];
        case (k)
            1: vals = '{27'd10000, 27'd10000000, 27'd10000, 27'd1, 27'd2, 27'd44100};
            2: vals = '{27'd0, 27'd0, 27'd0, 27'd0, 27'd0, 27'd0};
            // all ones: wider than most registers, so the upper bits are dropped
            3: vals = '{'1, '1, '1, '1, '1, '1};
            4: vals = '{27'd0, 27'h7FFFFFF, 27'd0, 27'd1, 27'd8, 27'd192000};
            // one byte rate of 2: huge buffer correction
            5: vals = '{27'd30000, 27'd100000000, 27'd1000000, 27'd1, 27'd1, 27'd1};
            // zero channels: no correction even though audio is on
            7: vals = '{27'd5000, 27'd50000, 27'd500, 27'd1, 27'd0, 27'd48000};
            default: vals = '{CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                              CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom)};
        endcase
        foreach (vals[n])
        begin
            cfg_we <= 1'b1;
            cfg_index <= REG_ORDER[n];
            cfg_data <= vals[n];
            @(posedge clk);
            sb.write_reg(REG_ORDER[n], vals[n]);
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_item_t it;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_SYNC_THR;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed events with the reset register values.
        it = '1;
        it.video_active = 1'b0;
        send_item(it, 0);                       // no video, everything else high
        it = '1;
        send_item(it, 0);                       // empty queue
        it = '0;
        send_item(it, 0);                       // no video, all low
        // first picture: zero step is bad, timer loads from the top of the time range
        it = '0;
        it.video_active = 1'b1;
        it.now_us = '1;
        send_item(it, 0);
        send_picture(33333, 0, '0, 20000);      // in sync, delay kept
        send_picture(1, 0, '0, 10499);          // smallest good step, rounds down
        send_picture(999999, 0, '0, 10500);     // largest good step, rounds up
        send_picture(1000000, 0, '0, 5000);     // step too long, last delay reused
        send_picture(0, 0, '0, 30000);          // repeated timestamp
        send_picture(-5000, 0, '0, 30000);      // timestamp went backward
        send_picture(40000, 200000, '0, 30000); // video ahead of audio: doubled
        send_picture(40000, -200000, '0, 30000);// video behind: zeroed
        send_picture(40000, 40000, '0, 30000);  // skew right at the threshold
        send_picture(40000, -40000, '0, 30000);
        send_picture(40000, 39999, '0, 30000);  // just under the threshold
        send_picture(40000, 10000000, '0, 30000); // at the no-sync limit: left alone
        send_picture(40000, 9999999, '0, 30000);
        send_picture(40000, 0, '1, 30000);      // full audio buffer correction
        send_picture(40000, 0, '0, -3000000);   // overdue: minimum delay
        send_picture(40000, 0, '0, 80000000);   // far off: saturates
        it = '1;
        it.queue_empty = 1'b0;
        send_item(it, 0);                       // every field at its top
        send_picture(40000, 0, '0, 0);          // wrapped timestamp after the top

        // Random phases, one register setting each.
        for (int phase = 1; phase <= NUM_SETTINGS; phase++)
        begin
            drain();
            program_setting(phase);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // back-to-back stretch in every phase; longer one around the hold
                tx_quiet = (i >= 30 && i < 50) || (phase == 6 && i >= 10 && i < 50);
                rx_quiet = (i >= 30 && i < 50) && phase != 6;
                if (phase == 6 && i == 10)
                    hold_req = 1'b1;
                if (phase == 3 && i == 58)
                    drain();
                send_item(random_event(), send_gap());
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: random ready with short and long stalls, a long hold
    // on request, and a monitor that checks every transfer.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else if (rx_quiet || $urandom_range(99) < 70)
                rsp_ready <= 1'b1;
            else
            begin
                rsp_ready <= 1'b0;
                stall_left = idle_len() - 1;
            end
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
